// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== design/tcpsr_pkg.sv =====
// types, constants and checksum helper for the tcp segment check block
`timescale 1ns / 1ps

package tcpsr_pkg;

  typedef enum logic [2:0] {
    VERD_HDR_ERR    = 3'd0,
    VERD_BAD_CKS    = 3'd1,
    VERD_RST_RCVD   = 3'd2,
    VERD_SUPPRESSED = 3'd3,
    VERD_SEND_RST   = 3'd4
  } verdict_t;

  localparam logic [7:0]  FLAG_FIN  = 8'h01;
  localparam logic [7:0]  FLAG_SYN  = 8'h02;
  localparam logic [7:0]  FLAG_RST  = 8'h04;
  localparam logic [7:0]  FLAG_ACK  = 8'h10;
  localparam logic [15:0] HDR_MIN   = 16'd20;
  localparam logic [15:0] PROTO_TCP = 16'd6;
  // data offset of 5 words in the reply header
  localparam logic [15:0] REPLY_OFF = 16'h5000;
  localparam int unsigned OUT_BYTES = 24;

  // ones-complement fold of a wide sum down to 16 bits
  function automatic logic [15:0] fold_sum(input logic [32:0] s);
    logic [17:0] a;
    logic [16:0] c;
    logic [16:0] d;
    a = {2'b00, s[15:0]} + {1'b0, s[32:16]};
    c = {1'b0, a[15:0]} + {15'd0, a[17:16]};
    d = {1'b0, c[15:0]} + {16'd0, c[16]};
    return d[15:0];
  endfunction

endpackage

// ===== design/tcp_segment_check_and_reset_reply.sv =====
// top level: tcp segment check with closed-port reset reply generation
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
// - in_* takes an ipv4 datagram carrying tcp, one byte per item, starting at
//   the ip header; in_tlast marks the final byte of the datagram
// - out_* carries exactly one item per datagram: the verdict and, for a
//   send-rst verdict, the reply header fields and reply checksum; the reply
//   fields are zero for every other verdict
// - throughput: one byte per cycle unless a stalled receiver holds the input side
//   (see below), with no gap needed between datagrams; once the last byte is
//   accepted, the result item reaches out_* through the input register, frame
//   snapshot, checksum and reply prep stage and output register, in that order
// - per-byte work is field capture by position and a 16-bit word add into
//   the running sum; the final checks run in the two stages after the snapshot
// - reset (rst_n low, synchronous) empties every stage and clears the
//   per-datagram state; the first byte after reset starts a new datagram
// - a stalled receiver holds the input side only once the output register,
//   the checks stage and the snapshot all hold results and another last byte
//   waits in the input register; ordinary bytes keep flowing until then
module tcp_segment_check_and_reset_reply (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] data_byte
  input  logic         in_tlast,    // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] verdict, [34:3] reply_src_addr, [66:35] reply_dst_addr,
  // [82:67] reply_src_port, [98:83] reply_dst_port, [130:99] reply_seq,
  // [162:131] reply_ack, [170:163] reply_flags, [186:171] reply_checksum,
  // [191:187] zero
  output logic [tcpsr_pkg::OUT_BYTES*8-1:0] out_tdata
);

  // ---------------- input register ----------------
  logic        s0_v_r;
  logic [7:0]  s0_b_r;
  logic        s0_last_r;

  // ---------------- per-datagram state ----------------
  logic [15:0] pos_r,  pos_nxt;
  logic [5:0]  ihl_r,  ihl_nxt;
  logic [15:0] len_r,  len_nxt;
  logic [31:0] src_r,  src_nxt;
  logic [31:0] dst_r,  dst_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [31:0] seq_r,  seq_nxt;
  logic [31:0] ack_r,  ack_nxt;
  logic [3:0]  hw_r,   hw_nxt;
  logic [7:0]  ctl_r,  ctl_nxt;
  logic [31:0] sum_r,  sum_nxt;
  logic [7:0]  held_r, held_nxt;

  // ---------------- frame snapshot (stage 1) ----------------
  logic        s1_v_r;
  logic [16:0] s1_count_r;
  logic [15:0] s1_total_r;
  logic [5:0]  s1_ihl_r;
  logic [3:0]  s1_hw_r;
  logic [7:0]  s1_ctl_r;
  logic [31:0] s1_sum_r;
  logic [7:0]  s1_held_r;
  logic [31:0] s1_src_r;
  logic [31:0] s1_dst_r;
  logic [15:0] s1_sport_r;
  logic [15:0] s1_dport_r;
  logic [31:0] s1_seq_r;
  logic [31:0] s1_ack_r;

  // ---------------- checks and reply prep (stage 2) ----------------
  logic        s2_v_r;
  logic        s2_hdr_err_r;
  logic [32:0] s2_cks_r;
  logic        s2_rst_in_r;
  logic        s2_unicast_r;
  logic [31:0] s2_rseq_r;
  logic [31:0] s2_rack_r;
  logic [7:0]  s2_rflags_r;
  logic [31:0] s2_src_r;
  logic [31:0] s2_dst_r;
  logic [15:0] s2_sport_r;
  logic [15:0] s2_dport_r;
  logic [19:0] s2_rpart_r;

  // ---------------- output register ----------------
  logic                 out_v_r;
  tcpsr_pkg::verdict_t  out_verdict_r;
  logic [31:0]          out_src_addr_r;
  logic [31:0]          out_dst_addr_r;
  logic [15:0]          out_src_port_r;
  logic [15:0]          out_dst_port_r;
  logic [31:0]          out_seq_r;
  logic [31:0]          out_ack_r;
  logic [7:0]           out_flags_r;
  logic [15:0]          out_cks_r;

  // ---------------- flow control ----------------
  logic out_ready;
  logic s2_go;
  logic s1_go;
  logic s0_done;
  logic in_acc;

  assign out_ready = !out_v_r || out_tready;
  assign s2_go     = !s2_v_r || out_ready;
  assign s1_go     = !s1_v_r || s2_go;
  // a non-last byte always completes; a last byte needs room in the snapshot
  assign s0_done   = s0_v_r && (!s0_last_r || s1_go);
  assign in_tready = !s0_v_r || s0_done;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_acc) begin
      s0_v_r <= 1'b1;
    end else if (s0_done) begin
      s0_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_b_r    <= in_tdata;
      s0_last_r <= in_tlast;
    end
  end

  // ---------------- per-byte capture and running sum ----------------
  logic [5:0]  ihl_eff;
  logic        in_seg;
  logic [15:0] rel;

  always_comb begin
    ihl_eff   = (pos_r == 16'd0) ? {s0_b_r[3:0], 2'b00} : ihl_r;
    ihl_nxt   = ihl_eff;
    len_nxt   = len_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    hw_nxt    = hw_r;
    ctl_nxt   = ctl_r;
    sum_nxt   = sum_r;
    held_nxt  = held_r;

    if (pos_r == 16'd2) begin
      len_nxt = {s0_b_r, len_r[7:0]};
    end
    if (pos_r == 16'd3) begin
      len_nxt = {len_r[15:8], s0_b_r};
    end
    if (pos_r inside {[16'd12:16'd15]}) begin
      src_nxt = {src_r[23:0], s0_b_r};
    end
    if (pos_r inside {[16'd16:16'd19]}) begin
      dst_nxt = {dst_r[23:0], s0_b_r};
    end

    // bytes from the tcp header on, up to the ip total length
    in_seg = (pos_r >= {10'd0, ihl_eff}) && (pos_r < 16'd4 || pos_r < len_r);
    rel    = pos_r - {10'd0, ihl_eff};
    if (in_seg) begin
      if (rel < 16'd2) begin
        sport_nxt = {sport_r[7:0], s0_b_r};
      end else if (rel < 16'd4) begin
        dport_nxt = {dport_r[7:0], s0_b_r};
      end else if (rel < 16'd8) begin
        seq_nxt = {seq_r[23:0], s0_b_r};
      end else if (rel < 16'd12) begin
        ack_nxt = {ack_r[23:0], s0_b_r};
      end else if (rel == 16'd12) begin
        hw_nxt = s0_b_r[7:4];
      end else if (rel == 16'd13) begin
        ctl_nxt = s0_b_r;
      end
      if (!rel[0]) begin
        held_nxt = s0_b_r;
      end else begin
        sum_nxt = sum_r + {16'd0, held_r, s0_b_r};
      end
    end

    // position saturates so later bytes fall past any total length
    pos_nxt = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s0_done && s0_last_r)) begin
      pos_r   <= '0;
      ihl_r   <= '0;
      len_r   <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      sport_r <= '0;
      dport_r <= '0;
      seq_r   <= '0;
      ack_r   <= '0;
      hw_r    <= '0;
      ctl_r   <= '0;
      sum_r   <= '0;
      held_r  <= '0;
    end else if (s0_done) begin
      pos_r   <= pos_nxt;
      ihl_r   <= ihl_nxt;
      len_r   <= len_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      seq_r   <= seq_nxt;
      ack_r   <= ack_nxt;
      hw_r    <= hw_nxt;
      ctl_r   <= ctl_nxt;
      sum_r   <= sum_nxt;
      held_r  <= held_nxt;
    end
  end

  // ---------------- stage 1: snapshot of the finished datagram ----------------
  logic s1_load;
  assign s1_load = s0_done && s0_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= 1'b1;
    end else if (s2_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_count_r <= {1'b0, pos_r} + 17'd1;
      s1_total_r <= len_nxt;
      s1_ihl_r   <= ihl_nxt;
      s1_hw_r    <= hw_nxt;
      s1_ctl_r   <= ctl_nxt;
      s1_sum_r   <= sum_nxt;
      s1_held_r  <= held_nxt;
      s1_src_r   <= src_nxt;
      s1_dst_r   <= dst_nxt;
      s1_sport_r <= sport_nxt;
      s1_dport_r <= dport_nxt;
      s1_seq_r   <= seq_nxt;
      s1_ack_r   <= ack_nxt;
    end
  end

  // ---------------- stage 2: length checks, checksum sum, reply fields ----------------
  logic        tot_ge;
  logic [15:0] tcpseg;
  logic [15:0] thoff;
  logic [15:0] dlen;
  logic        hdr_err;
  logic [32:0] cks_sum;
  logic        ack_set;
  logic [31:0] rseq;
  logic [31:0] rack;
  logic [7:0]  rflags;
  logic        unicast;
  logic [19:0] rpart;

  always_comb begin
    tot_ge  = s1_total_r >= {10'd0, s1_ihl_r};
    tcpseg  = tot_ge ? (s1_total_r - {10'd0, s1_ihl_r}) : 16'd0;
    thoff   = {10'd0, s1_hw_r, 2'b00};
    dlen    = tcpseg - thoff;
    hdr_err = (s1_count_r < {1'b0, tcpsr_pkg::HDR_MIN}) || (s1_count_r < {1'b0, s1_total_r})
           || !tot_ge || (tcpseg < tcpsr_pkg::HDR_MIN) || (thoff < tcpsr_pkg::HDR_MIN)
           || (thoff > tcpseg);

    // pseudo-header plus segment; odd segment pads the held byte with zero
    cks_sum = {1'b0, s1_sum_r}
            + (tcpseg[0] ? {17'd0, s1_held_r, 8'd0} : 33'd0)
            + {17'd0, s1_src_r[31:16]} + {17'd0, s1_src_r[15:0]}
            + {17'd0, s1_dst_r[31:16]} + {17'd0, s1_dst_r[15:0]}
            + {17'd0, tcpsr_pkg::PROTO_TCP} + {17'd0, tcpseg};

    ack_set = (s1_ctl_r & tcpsr_pkg::FLAG_ACK) != 8'd0;
    if (ack_set) begin
      rseq   = s1_ack_r;
      rack   = 32'd0;
      rflags = tcpsr_pkg::FLAG_RST;
    end else begin
      rseq   = 32'd0;
      rack   = s1_seq_r + {16'd0, dlen}
             + {31'd0, (s1_ctl_r & tcpsr_pkg::FLAG_SYN) != 8'd0}
             + {31'd0, (s1_ctl_r & tcpsr_pkg::FLAG_FIN) != 8'd0};
      rflags = tcpsr_pkg::FLAG_RST | tcpsr_pkg::FLAG_ACK;
    end

    // broadcast, zero and class d sources get no reply
    unicast = (s1_src_r != 32'd0) && (s1_src_r != 32'hFFFF_FFFF)
           && (s1_src_r[31:28] != 4'hE);

    // reply pseudo-header and port words
    rpart = {4'd0, s1_dst_r[31:16]} + {4'd0, s1_dst_r[15:0]}
          + {4'd0, s1_src_r[31:16]} + {4'd0, s1_src_r[15:0]}
          + {4'd0, tcpsr_pkg::PROTO_TCP + tcpsr_pkg::HDR_MIN}
          + {4'd0, s1_dport_r} + {4'd0, s1_sport_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_go) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s1_v_r) begin
      s2_hdr_err_r <= hdr_err;
      s2_cks_r     <= cks_sum;
      s2_rst_in_r  <= (s1_ctl_r & tcpsr_pkg::FLAG_RST) != 8'd0;
      s2_unicast_r <= unicast;
      s2_rseq_r    <= rseq;
      s2_rack_r    <= rack;
      s2_rflags_r  <= rflags;
      s2_src_r     <= s1_src_r;
      s2_dst_r     <= s1_dst_r;
      s2_sport_r   <= s1_sport_r;
      s2_dport_r   <= s1_dport_r;
      s2_rpart_r   <= rpart;
    end
  end

  // ---------------- stage 3: verdict and reply checksum ----------------
  tcpsr_pkg::verdict_t verdict;
  logic [19:0]         rsum;
  logic [15:0]         rcks;

  always_comb begin
    if (s2_hdr_err_r) begin
      verdict = tcpsr_pkg::VERD_HDR_ERR;
    end else if (tcpsr_pkg::fold_sum(s2_cks_r) != 16'hFFFF) begin
      verdict = tcpsr_pkg::VERD_BAD_CKS;
    end else if (s2_rst_in_r) begin
      verdict = tcpsr_pkg::VERD_RST_RCVD;
    end else if (!s2_unicast_r) begin
      verdict = tcpsr_pkg::VERD_SUPPRESSED;
    end else begin
      verdict = tcpsr_pkg::VERD_SEND_RST;
    end

    rsum = s2_rpart_r
         + {4'd0, s2_rseq_r[31:16]} + {4'd0, s2_rseq_r[15:0]}
         + {4'd0, s2_rack_r[31:16]} + {4'd0, s2_rack_r[15:0]}
         + {4'd0, tcpsr_pkg::REPLY_OFF | {8'd0, s2_rflags_r}};
    rcks = ~tcpsr_pkg::fold_sum({13'd0, rsum});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_v_r) begin
      out_verdict_r <= verdict;
      if (verdict == tcpsr_pkg::VERD_SEND_RST) begin
        out_src_addr_r <= s2_dst_r;
        out_dst_addr_r <= s2_src_r;
        out_src_port_r <= s2_dport_r;
        out_dst_port_r <= s2_sport_r;
        out_seq_r      <= s2_rseq_r;
        out_ack_r      <= s2_rack_r;
        out_flags_r    <= s2_rflags_r;
        out_cks_r      <= rcks;
      end else begin
        out_src_addr_r <= '0;
        out_dst_addr_r <= '0;
        out_src_port_r <= '0;
        out_dst_port_r <= '0;
        out_seq_r      <= '0;
        out_ack_r      <= '0;
        out_flags_r    <= '0;
        out_cks_r      <= '0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_cks_r, out_flags_r, out_ack_r, out_seq_r,
                       out_dst_port_r, out_src_port_r, out_dst_addr_r,
                       out_src_addr_r, out_verdict_r};

  // ---------------- assertions ----------------
  `ASSERT_PROP(a_reply_zero_unless_send, clk, rst_n,
    (out_v_r && out_verdict_r != tcpsr_pkg::VERD_SEND_RST) |-> (out_flags_r == 8'd0 && out_cks_r == 16'd0 && out_seq_r == 32'd0 && out_ack_r == 32'd0))
  `ASSERT_PROP(a_send_flags_legal, clk, rst_n,
    (out_v_r && out_verdict_r == tcpsr_pkg::VERD_SEND_RST) |-> (out_flags_r == tcpsr_pkg::FLAG_RST || out_flags_r == (tcpsr_pkg::FLAG_RST | tcpsr_pkg::FLAG_ACK)))
  `ASSERT_PROP(a_state_clear_after_last, clk, rst_n,
    (s0_done && s0_last_r) |=> (pos_r == 16'd0 && sum_r == 32'd0 && ihl_r == 6'd0))
  `ASSERT_NEVER(a_snapshot_overrun, clk, rst_n, s1_load && s1_v_r && !s2_go)

endmodule
